>>> src/door_guard_controller_defines.svh
// Assertion macros for the door guard controller.
// Included by the files that carry concurrent assertions.
`ifndef DOOR_GUARD_CONTROLLER_DEFINES_SVH
`define DOOR_GUARD_CONTROLLER_DEFINES_SVH
`ifndef SYNTHESIS
`define DGC_ASSERT(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error("%m failed");
`define DGC_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) else $error("%m failed");
`else
`define DGC_ASSERT(label, clk, rst_n, prop)
`define DGC_ASSERT_ALWAYS(label, clk, prop)
`endif
`endif

>>> src/dgc_pkg.sv
// Package of the door guard controller: types, codes and constants.
// No dependencies.
`timescale 1ns / 1ps
package dgc_pkg;
  typedef enum logic [2:0] {
    ST_IDLE = 3'd0, ST_WARNING = 3'd1, ST_NOWARN = 3'd2, ST_DELAYED = 3'd3,
    ST_DELAYED2 = 3'd4, ST_RSV5 = 3'd5, ST_RSV6 = 3'd6, ST_RSV7 = 3'd7
  } guard_st_e;

  typedef enum logic [2:0] {
    REG_MIN_PRESS = 3'd0, REG_DOUBLE_GAP = 3'd1, REG_SHORT_MAX = 3'd2,
    REG_LONG_MAX = 3'd3, REG_DELAY_BLINK = 3'd4, REG_ALARM_BLINK = 3'd5,
    REG_SAMPLE = 3'd6, REG_BUZZ = 3'd7
  } reg_idx_e;

  typedef enum logic [1:0] {FSM_IDLE, FSM_READ, FSM_CALC, FSM_OUT} fsm_e;

  // Per-channel record held in the channel RAM
  typedef struct packed {
    logic        armed;
    logic        was_opened;
    logic        was_closed;
    logic        blink_phase;
    logic [2:0]  status;
    logic        press_valid;
    logic [31:0] press_start;
    logic        release_valid;
    logic [31:0] release_time;
    logic [31:0] held;
    logic        blink_valid;
    logic [31:0] blink_time;
    logic        status_led;
    logic        warning_led;
  } chan_t;

  localparam int ChanW = $bits(chan_t);

  typedef struct packed {
    logic [15:0] min_press;
    logic [15:0] double_gap;
    logic [15:0] short_max;
    logic [15:0] long_max;
    logic [15:0] delay_blink;
    logic [15:0] alarm_blink;
  } cfg_t;

  localparam chan_t ChanReset = '0;

  function automatic logic [10:0] melody(input logic [1:0] idx);
    case (idx)
      2'd0:    melody = 11'd1915;
      2'd1:    melody = 11'd1275;
      default: melody = 11'd956;
    endcase
  endfunction
endpackage

>>> src/dgc_if.sv
// Valid/ready channel interfaces for requests, results and config writes.
// Depends on nothing.
`timescale 1ns / 1ps
interface dgc_in_if;
  logic        valid;
  logic        ready;
  logic [31:0] now_ms;
  logic [7:0]  button_levels;
  logic [7:0]  door_levels;
  modport source (output valid, now_ms, button_levels, door_levels, input ready);
  modport sink (input valid, now_ms, button_levels, door_levels, output ready);
endinterface

interface dgc_out_if;
  logic        valid;
  logic        ready;
  logic [7:0]  status_leds;
  logic [7:0]  warning_leds;
  logic        tone_start;
  logic [10:0] tone_value;
  logic        tone_silence;
  logic        save_request;
  modport source (output valid, status_leds, warning_leds, tone_start, tone_value,
                  tone_silence, save_request, input ready);
  modport sink (input valid, status_leds, warning_leds, tone_start, tone_value,
                tone_silence, save_request, output ready);
endinterface

interface dgc_cfg_if;
  logic        valid;
  logic        ready;
  logic [2:0]  index;
  logic [15:0] data;
  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

>>> src/door_guard_controller.sv
// Door guard controller top level: sweep sequencer over the channel RAM.
// Depends on dgc_pkg, dgc_if, dgc_ram, dgc_chan and the defines header.
// A request is taken only while the sequencer is idle and the last result has been
// handed off. Each channel then gets a RAM read state and an update/write-back state
// on the channel RAM (one write port, one read port), and FSM_OUT registers the result.
// Reset: a valid bit per entry marks channel records as reset; config regs to defaults.
`timescale 1ns / 1ps
`include "door_guard_controller_defines.svh"
module door_guard_controller #(
  parameter int CHANNELS = 8
) (
  input  logic clk_i,
  input  logic rst_ni,
  dgc_in_if.sink    in_if,
  dgc_out_if.source out_if,
  dgc_cfg_if.sink   cfg_if
);
  localparam int AW = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
  localparam int DEPTH = 1 << AW;

  dgc_pkg::cfg_t cfg_q;
  logic [15:0] sample_q, buzz_q;
  dgc_pkg::fsm_e fsm_q, fsm_d;
  logic [AW-1:0] ch_q, ch_d;
  logic [31:0] t_q, last_sample_q, last_note_q;
  logic [7:0] btn_q, door_q, sled_q, wled_q;
  logic sample_q2, buzzing_q, save_q;
  logic [1:0] note_q;
  logic [DEPTH-1:0] vld_q;
  logic out_valid_q, start_q, silence_q;
  logic [10:0] tone_q;

  logic [dgc_pkg::ChanW-1:0] rdata;
  dgc_pkg::chan_t cur, nxt;
  logic save_c, buzz_c, we;
  logic last_ch;
  logic in_acc;

  assign cfg_if.ready = 1'b1;
  assign in_if.ready = (fsm_q == dgc_pkg::FSM_IDLE) && !out_valid_q;
  assign in_acc = in_if.valid && in_if.ready;
  assign last_ch = (32'(ch_q) == CHANNELS - 1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q <= '{16'd50, 16'd200, 16'd500, 16'd2500, 16'd500, 16'd250};
      sample_q <= 16'd100;
      buzz_q <= 16'd50;
    end else if (cfg_if.valid) begin
      case (dgc_pkg::reg_idx_e'(cfg_if.index))
        dgc_pkg::REG_MIN_PRESS:   cfg_q.min_press <= cfg_if.data;
        dgc_pkg::REG_DOUBLE_GAP:  cfg_q.double_gap <= cfg_if.data;
        dgc_pkg::REG_SHORT_MAX:   cfg_q.short_max <= cfg_if.data;
        dgc_pkg::REG_LONG_MAX:    cfg_q.long_max <= cfg_if.data;
        dgc_pkg::REG_DELAY_BLINK: cfg_q.delay_blink <= cfg_if.data;
        dgc_pkg::REG_ALARM_BLINK: cfg_q.alarm_blink <= cfg_if.data;
        dgc_pkg::REG_SAMPLE:      sample_q <= cfg_if.data;
        dgc_pkg::REG_BUZZ:        buzz_q <= cfg_if.data;
        default: ;
      endcase
    end
  end

  assign we = (fsm_q == dgc_pkg::FSM_CALC);

  dgc_ram #(.Width(dgc_pkg::ChanW), .Depth(DEPTH)) u_ram (
    .clk_i(clk_i), .we_i(we), .waddr_i(ch_q), .wdata_i(nxt),
    .raddr_i(ch_q), .rdata_o(rdata)
  );

  assign cur = vld_q[ch_q] ? dgc_pkg::chan_t'(rdata) : dgc_pkg::ChanReset;

  dgc_chan u_chan (
    .cur_i(cur), .cfg_i(cfg_q), .t_i(t_q), .pressed_i(btn_q[ch_q]),
    .closed_i(door_q[ch_q]), .sample_i(sample_q2), .nxt_o(nxt),
    .save_o(save_c), .buzz_o(buzz_c)
  );

  always_comb begin
    fsm_d = fsm_q;
    ch_d = ch_q;
    case (fsm_q)
      dgc_pkg::FSM_IDLE: if (in_acc) begin
        fsm_d = dgc_pkg::FSM_READ;
        ch_d = '0;
      end
      dgc_pkg::FSM_READ: fsm_d = dgc_pkg::FSM_CALC;
      dgc_pkg::FSM_CALC: begin
        if (last_ch) fsm_d = dgc_pkg::FSM_OUT;
        else begin
          fsm_d = dgc_pkg::FSM_READ;
          ch_d = ch_q + 1'b1;
        end
      end
      dgc_pkg::FSM_OUT: fsm_d = dgc_pkg::FSM_IDLE;
      default: fsm_d = dgc_pkg::FSM_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fsm_q <= dgc_pkg::FSM_IDLE;
      ch_q <= '0;
      vld_q <= '0;
      last_sample_q <= '0;
      last_note_q <= '0;
      note_q <= '0;
      out_valid_q <= 1'b0;
      sample_q2 <= 1'b0;
      buzzing_q <= 1'b0;
      save_q <= 1'b0;
    end else begin
      fsm_q <= fsm_d;
      ch_q <= ch_d;
      if (out_valid_q && out_if.ready) out_valid_q <= 1'b0;
      if (in_acc) begin
        t_q <= in_if.now_ms;
        btn_q <= in_if.button_levels;
        door_q <= in_if.door_levels;
        sled_q <= '0;
        wled_q <= '0;
        buzzing_q <= 1'b0;
        save_q <= 1'b0;
        if ((in_if.now_ms - last_sample_q) > 32'(sample_q)) begin
          last_sample_q <= in_if.now_ms;
          sample_q2 <= 1'b1;
        end else sample_q2 <= 1'b0;
      end
      if (we) begin
        vld_q[ch_q] <= 1'b1;
        sled_q[ch_q] <= nxt.status_led;
        wled_q[ch_q] <= nxt.warning_led;
        if (buzz_c) buzzing_q <= 1'b1;
        if (save_c) save_q <= 1'b1;
      end
      if (fsm_q == dgc_pkg::FSM_OUT) begin
        out_valid_q <= 1'b1;
        start_q <= 1'b0;
        tone_q <= '0;
        silence_q <= !buzzing_q;
        if (buzzing_q) begin
          if ((t_q - last_note_q) > 32'(buzz_q)) begin
            start_q <= 1'b1;
            tone_q <= dgc_pkg::melody(note_q);
            note_q <= note_q + 2'd1;
            last_note_q <= t_q;
          end
        end else note_q <= '0;
      end
    end
  end

  assign out_if.valid = out_valid_q;
  assign out_if.status_leds = sled_q;
  assign out_if.warning_leds = wled_q;
  assign out_if.tone_start = start_q;
  assign out_if.tone_value = tone_q;
  assign out_if.tone_silence = silence_q;
  assign out_if.save_request = save_q;

  `DGC_ASSERT(a_no_accept_busy, clk_i, rst_ni, (fsm_q != dgc_pkg::FSM_IDLE) |-> !in_if.ready)
  `DGC_ASSERT(a_out_after_sweep, clk_i, rst_ni, $rose(out_valid_q) |-> $past(fsm_q == dgc_pkg::FSM_OUT))
  `DGC_ASSERT(a_tone_only_start, clk_i, rst_ni, out_valid_q && !start_q |-> tone_q == 11'd0)
  `DGC_ASSERT(a_silence_no_start, clk_i, rst_ni, out_valid_q && silence_q |-> !start_q)
endmodule

>>> src/dgc_ram.sv
// Generic single-port-write, single-read RAM with registered read.
// No dependencies.
`timescale 1ns / 1ps
module dgc_ram #(
  parameter int Width = 8,
  parameter int Depth = 8
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];
  always_ff @(posedge clk_i) begin
    if (we_i) mem_q[waddr_i] <= wdata_i;
    rdata_o <= mem_q[raddr_i];
  end
endmodule

>>> src/dgc_chan.sv
// Per-channel update: button click decoding and door status machine.
// Uses dgc_pkg.
`timescale 1ns / 1ps
module dgc_chan (
  input  dgc_pkg::chan_t  cur_i,
  input  dgc_pkg::cfg_t   cfg_i,
  input  logic [31:0]     t_i,
  input  logic            pressed_i,
  input  logic            closed_i,
  input  logic            sample_i,
  output dgc_pkg::chan_t  nxt_o,
  output logic            save_o,
  output logic            buzz_o
);
  always_comb begin
    dgc_pkg::chan_t c;
    logic [31:0] dur, dt;
    logic        click, dbl;
    logic [31:0] cdur;
    logic [2:0]  st;
    logic        delayed;
    logic [31:0] ival;
    logic        led;
    c = cur_i;
    save_o = 1'b0;
    click = 1'b0;
    dbl = 1'b0;
    cdur = '0;
    dur = '0;
    dt = '0;
    led = 1'b0;
    // button
    if (pressed_i) begin
      if (!c.press_valid) begin
        c.press_valid = 1'b1;
        c.press_start = t_i;
      end
    end else begin
      if (c.press_valid) begin
        dur = t_i - c.press_start;
        c.press_valid = 1'b0;
        if (dur > 32'(cfg_i.min_press)) begin
          if (!c.release_valid) begin
            c.held = dur;
            c.release_valid = 1'b1;
            c.release_time = t_i;
          end else begin
            click = 1'b1;
            dbl = 1'b1;
            c.release_valid = 1'b0;
          end
        end
      end
      dt = t_i - c.release_time;
      if (!click && c.release_valid && dt > 32'(cfg_i.double_gap)) begin
        click = 1'b1;
        cdur = c.held;
        c.release_valid = 1'b0;
      end
    end
    if (click) begin
      if (dbl) begin
        if (c.armed) c.status = dgc_pkg::ST_DELAYED;
      end else if (cdur > 32'(cfg_i.min_press) && cdur <= 32'(cfg_i.short_max)) begin
        if (c.armed) begin
          c.status = dgc_pkg::ST_NOWARN;
          c.was_opened = 1'b0;
        end
      end else if (cdur > 32'(cfg_i.short_max) && cdur <= 32'(cfg_i.long_max)) begin
        if (c.armed) begin
          c.armed = 1'b0;
          c.status_led = 1'b0;
          c.warning_led = 1'b0;
          c.blink_valid = 1'b0;
          c.blink_phase = 1'b0;
          c.was_opened = 1'b0;
          c.press_valid = 1'b0;
        end else begin
          c.status_led = 1'b1;
          c.armed = 1'b1;
        end
        save_o = 1'b1;
      end
    end
    // door
    st = c.status;
    delayed = (st == dgc_pkg::ST_DELAYED) || (st == dgc_pkg::ST_DELAYED2);
    ival = delayed ? 32'(cfg_i.delay_blink) : 32'(cfg_i.alarm_blink);
    if (sample_i) begin
      if (!closed_i) c.was_closed = 1'b1;
      if (delayed || (!closed_i && c.armed)) begin
        led = delayed ? c.status_led : c.warning_led;
        if (!c.blink_valid) begin
          c.blink_valid = 1'b1;
          c.blink_time = t_i;
          led = 1'b0;
        end else if ((t_i - c.blink_time) > ival) begin
          c.blink_phase = !c.blink_phase;
          c.blink_time = t_i;
          led = c.blink_phase;
        end
        if (delayed) c.status_led = led;
        else c.warning_led = led;
      end
      if (delayed) begin
        if (closed_i && st == dgc_pkg::ST_DELAYED2) c.status = dgc_pkg::ST_IDLE;
        else if (!closed_i && st == dgc_pkg::ST_DELAYED) c.status = dgc_pkg::ST_DELAYED2;
      end else begin
        c.status_led = c.armed;
        if (closed_i) begin
          c.blink_valid = 1'b0;
          if (st == dgc_pkg::ST_NOWARN) c.status = dgc_pkg::ST_IDLE;
          c.warning_led = c.was_opened;
        end else if (c.armed) begin
          if (st != dgc_pkg::ST_NOWARN) c.status = dgc_pkg::ST_WARNING;
          c.was_opened = 1'b1;
        end else if (c.was_closed && c.was_opened) begin
          c.status_led = 1'b0;
          c.warning_led = 1'b1;
        end
      end
    end
    buzz_o = c.armed && (c.status == dgc_pkg::ST_WARNING);
    nxt_o = c;
  end
endmodule

>>> tb/sv/door_guard_controller_tb.sv
// Self-checking testbench of door_guard_controller: directed sweeps, then random
// sweeps under several register settings, checked against an in-bench predictor.
// Depends on dgc_pkg, dgc_if and the RTL of the controller.
`timescale 1ns / 1ps
module door_guard_controller_tb;

  localparam int NCH = 8;
  localparam int STALL_LIMIT = 5000;

  typedef struct packed {
    logic [7:0]  status_leds;
    logic [7:0]  warning_leds;
    logic        tone_start;
    logic [10:0] tone_value;
    logic        tone_silence;
    logic        save_request;
  } sweep_res_t;

  typedef struct {
    logic [31:0] now;
    logic [7:0]  buttons;
    logic [7:0]  doors;
    bit          typed;
    sweep_res_t  res;
  } sweep_row_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  dgc_in_if  in_if ();
  dgc_out_if out_if ();
  dgc_cfg_if cfg_if ();

  door_guard_controller #(.CHANNELS(NCH)) u_dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_if  (in_if),
    .out_if (out_if),
    .cfg_if (cfg_if)
  );

  always #1 clk_i = ~clk_i;

  // Predictor state
  logic [15:0] reg_val [8];
  bit          armed_q [NCH], opened_q [NCH], closed_q [NCH], phase_q [NCH];
  dgc_pkg::guard_st_e st_q [NCH];
  bit          press_v [NCH], rel_v [NCH], blink_v [NCH];
  logic [31:0] press_t [NCH], rel_t [NCH], held_q [NCH], blink_t [NCH];
  bit          sled_q [NCH], wled_q [NCH];
  logic [31:0] last_sample, last_note;
  logic [1:0]  note_idx;
  bit          save_q;

  sweep_res_t  pending_sweeps [$];
  bit          failed = 1'b0;
  bit          idle_on = 1'b1;
  bit          hold_req = 1'b0;
  bit          hold_on = 1'b0;
  int          quiet_cycles = 0;

  function automatic void model_reset();
    reg_val[dgc_pkg::REG_MIN_PRESS] = 16'd50;
    reg_val[dgc_pkg::REG_DOUBLE_GAP] = 16'd200;
    reg_val[dgc_pkg::REG_SHORT_MAX] = 16'd500;
    reg_val[dgc_pkg::REG_LONG_MAX] = 16'd2500;
    reg_val[dgc_pkg::REG_DELAY_BLINK] = 16'd500;
    reg_val[dgc_pkg::REG_ALARM_BLINK] = 16'd250;
    reg_val[dgc_pkg::REG_SAMPLE] = 16'd100;
    reg_val[dgc_pkg::REG_BUZZ] = 16'd50;
    for (int c = 0; c < NCH; c++) begin
      armed_q[c] = 0; opened_q[c] = 0; closed_q[c] = 0; phase_q[c] = 0;
      st_q[c] = dgc_pkg::ST_IDLE; press_v[c] = 0; rel_v[c] = 0; blink_v[c] = 0;
      press_t[c] = 0; rel_t[c] = 0; held_q[c] = 0; blink_t[c] = 0;
      sled_q[c] = 0; wled_q[c] = 0;
    end
    last_sample = 0; last_note = 0; note_idx = 0; save_q = 0;
  endfunction

  function automatic void decide_click(int c, logic [31:0] dur, bit dbl);
    if (dbl) begin
      if (armed_q[c]) st_q[c] = dgc_pkg::ST_DELAYED;
    end else if (dur > reg_val[dgc_pkg::REG_MIN_PRESS] &&
                 dur <= reg_val[dgc_pkg::REG_SHORT_MAX]) begin
      if (armed_q[c]) begin
        st_q[c] = dgc_pkg::ST_NOWARN;
        opened_q[c] = 0;
      end
    end else if (dur > reg_val[dgc_pkg::REG_SHORT_MAX] &&
                 dur <= reg_val[dgc_pkg::REG_LONG_MAX]) begin
      if (armed_q[c]) begin
        armed_q[c] = 0; sled_q[c] = 0; wled_q[c] = 0; blink_v[c] = 0;
        phase_q[c] = 0; opened_q[c] = 0; press_v[c] = 0;
      end else begin
        sled_q[c] = 1;
        armed_q[c] = 1;
      end
      save_q = 1;
    end
  endfunction

  function automatic void button_step(int c, logic [31:0] t, bit pressed);
    logic [31:0] dur;
    if (pressed) begin
      if (!press_v[c]) begin
        press_v[c] = 1;
        press_t[c] = t;
      end
      return;
    end
    if (press_v[c]) begin
      dur = t - press_t[c];
      press_v[c] = 0;
      if (dur > reg_val[dgc_pkg::REG_MIN_PRESS]) begin
        if (!rel_v[c]) begin
          held_q[c] = dur; rel_v[c] = 1; rel_t[c] = t;
        end else begin
          decide_click(c, 0, 1);
          rel_v[c] = 0;
        end
      end
    end
    if (rel_v[c] && (t - rel_t[c]) > reg_val[dgc_pkg::REG_DOUBLE_GAP]) begin
      decide_click(c, held_q[c], 0);
      rel_v[c] = 0;
    end
  endfunction

  // Returns the new LED level
  function automatic bit blink_step(int c, logic [31:0] t, logic [15:0] ival, bit led);
    if (!blink_v[c]) begin
      blink_v[c] = 1; blink_t[c] = t;
      return 1'b0;
    end
    if ((t - blink_t[c]) > ival) begin
      phase_q[c] = !phase_q[c];
      blink_t[c] = t;
      return phase_q[c];
    end
    return led;
  endfunction

  function automatic void door_step(int c, logic [31:0] t, bit shut);
    dgc_pkg::guard_st_e st;
    st = st_q[c];
    if (!shut) closed_q[c] = 1;
    if (st == dgc_pkg::ST_DELAYED || st == dgc_pkg::ST_DELAYED2) begin
      sled_q[c] = blink_step(c, t, reg_val[dgc_pkg::REG_DELAY_BLINK], sled_q[c]);
      if (shut && st == dgc_pkg::ST_DELAYED2) st_q[c] = dgc_pkg::ST_IDLE;
      else if (!shut && st == dgc_pkg::ST_DELAYED) st_q[c] = dgc_pkg::ST_DELAYED2;
      return;
    end
    sled_q[c] = armed_q[c];
    if (shut) begin
      blink_v[c] = 0;
      if (st == dgc_pkg::ST_NOWARN) st_q[c] = dgc_pkg::ST_IDLE;
      wled_q[c] = opened_q[c];
    end else if (armed_q[c]) begin
      wled_q[c] = blink_step(c, t, reg_val[dgc_pkg::REG_ALARM_BLINK], wled_q[c]);
      if (st != dgc_pkg::ST_NOWARN) st_q[c] = dgc_pkg::ST_WARNING;
      opened_q[c] = 1;
    end else if (closed_q[c] && opened_q[c]) begin
      sled_q[c] = 0;
      wled_q[c] = 1;
    end
  endfunction

  function automatic sweep_res_t predict_sweep(logic [31:0] t, logic [7:0] b, logic [7:0] d);
    sweep_res_t r;
    bit sample, buzzing;
    r = '0; sample = 0; buzzing = 0; save_q = 0;
    if ((t - last_sample) > reg_val[dgc_pkg::REG_SAMPLE]) begin
      last_sample = t;
      sample = 1;
    end
    for (int c = 0; c < NCH; c++) begin
      button_step(c, t, b[c]);
      if (sample) door_step(c, t, d[c]);
      if (armed_q[c] && st_q[c] == dgc_pkg::ST_WARNING) buzzing = 1;
      r.status_leds[c] = sled_q[c];
      r.warning_leds[c] = wled_q[c];
    end
    if (buzzing) begin
      if ((t - last_note) > reg_val[dgc_pkg::REG_BUZZ]) begin
        r.tone_start = 1;
        r.tone_value = (note_idx == 0) ? 11'd1915 : (note_idx == 1) ? 11'd1275 : 11'd956;
        note_idx = note_idx + 1;
        last_note = t;
      end
    end else begin
      note_idx = 0;
      r.tone_silence = 1;
    end
    r.save_request = save_q;
    return r;
  endfunction

  // Drivers: called at a falling edge, return at a falling edge
  task automatic write_reg(dgc_pkg::reg_idx_e idx, logic [15:0] v);
    cfg_if.valid = 1'b1; cfg_if.index = idx; cfg_if.data = v;
    do @(posedge clk_i); while (!cfg_if.ready);
    reg_val[idx] = v;
    @(negedge clk_i);
    cfg_if.valid = 1'b0;
  endtask

  task automatic send_sweep(logic [31:0] t, logic [7:0] b, logic [7:0] d,
                            bit typed, sweep_res_t typed_res);
    sweep_res_t r;
    while (idle_on && $urandom_range(0, 99) < 33) begin
      in_if.valid = 1'b0;
      @(negedge clk_i);
    end
    in_if.valid = 1'b1; in_if.now_ms = t; in_if.button_levels = b; in_if.door_levels = d;
    do @(posedge clk_i); while (!in_if.ready);
    r = predict_sweep(t, b, d);
    pending_sweeps.push_back(typed ? typed_res : r);
    @(negedge clk_i);
  endtask

  task automatic drain();
    in_if.valid = 1'b0;
    while (pending_sweeps.size() != 0) @(negedge clk_i);
    repeat (24) @(negedge clk_i);
  endtask

  // Receiver side
  always @(negedge clk_i) begin
    if (hold_on) out_if.ready <= 1'b0;
    else out_if.ready <= !idle_on || ($urandom_range(0, 99) >= 33);
  end

  initial begin
    wait (hold_req);
    @(negedge clk_i);
    hold_on = 1'b1;
    repeat (400) @(negedge clk_i);
    hold_on = 1'b0;
  end

  function automatic void check_field(string name, int unsigned want, int unsigned got);
    if (want != got) begin
      failed = 1'b1;
      $display("%0t: %s expected %0d actual %0d", $realtime, name, want, got);
    end
  endfunction

  always @(posedge clk_i) begin
    sweep_res_t w;
    if (out_if.valid && out_if.ready) begin
      if (pending_sweeps.size() == 0) begin
        failed = 1'b1;
        $display("%0t: result with no request pending, expected none actual %h", $realtime,
                 {out_if.status_leds, out_if.warning_leds});
      end else begin
        w = pending_sweeps.pop_front();
        check_field("status_leds", w.status_leds, out_if.status_leds);
        check_field("warning_leds", w.warning_leds, out_if.warning_leds);
        check_field("tone_start", w.tone_start, out_if.tone_start);
        check_field("tone_value", w.tone_value, out_if.tone_value);
        check_field("tone_silence", w.tone_silence, out_if.tone_silence);
        check_field("save_request", w.save_request, out_if.save_request);
      end
    end
  end

  // Watchdog on cycles without any handshake
  always @(posedge clk_i) begin
    if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready) ||
        (cfg_if.valid && cfg_if.ready) || !rst_ni) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    sweep_row_t  rows [$];
    sweep_row_t  row;
    sweep_res_t  quiet;
    logic [31:0] t;
    logic [7:0]  btn, door;
    int          step_max;
    logic [15:0] vals [8];

    in_if.valid = 0; in_if.now_ms = 0; in_if.button_levels = 0; in_if.door_levels = 0;
    cfg_if.valid = 0; cfg_if.index = dgc_pkg::REG_MIN_PRESS; cfg_if.data = 0;
    out_if.ready = 0;
    model_reset();
    repeat (8) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    quiet = '0;
    quiet.tone_silence = 1'b1;
    // after reset, then a wrapped time with every door closed
    rows.push_back('{32'd0, 8'h00, 8'h00, 1, quiet});
    rows.push_back('{32'hFFFF_FFFF, 8'h00, 8'hFF, 1, quiet});
    // long click on every channel arms it, then doors open: warning and melody
    rows.push_back('{32'd1000, 8'hFF, 8'hFF, 0, quiet});
    rows.push_back('{32'd2000, 8'h00, 8'hFF, 0, quiet});
    rows.push_back('{32'd2300, 8'h00, 8'hFF, 0, quiet});
    rows.push_back('{32'd2500, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd2560, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd2700, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd2760, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd2900, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd3000, 8'h00, 8'h00, 0, quiet});
    // short click mutes the low half, double click delays the high half
    rows.push_back('{32'd3100, 8'hFF, 8'h00, 0, quiet});
    rows.push_back('{32'd3300, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd3350, 8'hF0, 8'h00, 0, quiet});
    rows.push_back('{32'd3450, 8'h00, 8'h0F, 0, quiet});
    rows.push_back('{32'd3700, 8'h00, 8'hFF, 0, quiet});
    rows.push_back('{32'd3900, 8'h00, 8'h00, 0, quiet});
    rows.push_back('{32'd4500, 8'h00, 8'hFF, 0, quiet});
    // hold too short, hold beyond the long range, then long click disarms
    rows.push_back('{32'd5000, 8'h01, 8'hFF, 0, quiet});
    rows.push_back('{32'd5020, 8'h00, 8'hFF, 0, quiet});
    rows.push_back('{32'd5100, 8'h02, 8'hFF, 0, quiet});
    rows.push_back('{32'd9000, 8'h0C, 8'hFF, 0, quiet});
    rows.push_back('{32'd10000, 8'h00, 8'hAA, 0, quiet});
    rows.push_back('{32'd10500, 8'h00, 8'h55, 0, quiet});
    foreach (rows[i]) begin
      row = rows[i];
      send_sweep(row.now, row.buttons, row.doors, row.typed, row.res);
    end
    drain();

    t = $urandom;
    btn = 0;
    door = 8'hFF;
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: vals = '{50, 200, 500, 2500, 500, 250, 100, 50};
        1: vals = '{0, 0, 0, 0, 0, 0, 0, 0};
        2: vals = '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF,
                    16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF};
        3: vals = '{10, 60, 150, 400, 80, 40, 20, 10};
        default: foreach (vals[k]) vals[k] = $urandom_range(0, 1500);
      endcase
      for (int k = 0; k < 8; k++) write_reg(dgc_pkg::reg_idx_e'(k), vals[k]);
      step_max = (ph == 2) ? 40000 : (ph == 1) ? 20 : 300;
      for (int n = 0; n < 240; n++) begin
        idle_on = !(ph == 3 && n >= 40 && n < 200);
        if (ph == 0 && n == 100) hold_req = 1'b1;
        if ($urandom_range(0, 99) < 3) t = t + $urandom;
        else t = t + $urandom_range(0, step_max);
        if ($urandom_range(0, 99) < 5) begin
          btn = $urandom;
          door = $urandom;
        end else begin
          for (int c = 0; c < NCH; c++) begin
            if ($urandom_range(0, 99) < 30) btn[c] = !btn[c];
            if ($urandom_range(0, 99) < 10) door[c] = !door[c];
          end
        end
        send_sweep(t, btn, door, 0, quiet);
      end
      drain();
    end
    idle_on = 1'b1;

    if (!failed) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end
endmodule
